### design/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; a clk and rst_n must be in scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define CHK_RUN(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define CHK_ALL(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/e2q_pkg.sv
// Shared constants, types and tables of the Euler to quaternion unit.
// Depends on nothing.
package e2q_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 30;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam int QW        = 34;
    localparam int MOD_STEPS = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [32:0] DEG360_Q16 = 33'd23592960;
    localparam logic [32:0] MOD_OFFSET = 33'd2170552320;
    localparam logic signed [QW-1:0] DEG90_Q24  = 34'sd1509949440;
    localparam logic signed [QW-1:0] DEG180_Q24 = 34'sd3019898880;
    localparam logic signed [QW-1:0] GAIN_Q30   = 34'sd652032874;

    typedef logic signed [QW-1:0] q30_t;

    typedef struct packed {
        logic [2:0][QW-1:0] z;
        logic [2:0]         flip;
    } front_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic q30_t atan_q24(input int idx);
        q30_t v;
        case (idx)
            0:  v = 34'sd754974720;
            1:  v = 34'sd445687602;
            2:  v = 34'sd235489088;
            3:  v = 34'sd119537938;
            4:  v = 34'sd60000934;
            5:  v = 34'sd30029717;
            6:  v = 34'sd15018523;
            7:  v = 34'sd7509720;
            8:  v = 34'sd3754917;
            9:  v = 34'sd1877466;
            10: v = 34'sd938734;
            11: v = 34'sd469367;
            12: v = 34'sd234684;
            13: v = 34'sd117342;
            14: v = 34'sd58671;
            15: v = 34'sd29335;
            16: v = 34'sd14668;
            17: v = 34'sd7334;
            18: v = 34'sd3667;
            19: v = 34'sd1833;
            20: v = 34'sd917;
            21: v = 34'sd458;
            22: v = 34'sd229;
            23: v = 34'sd115;
            24: v = 34'sd57;
            25: v = 34'sd29;
            26: v = 34'sd14;
            27: v = 34'sd7;
            28: v = 34'sd4;
            29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/e2q_front.sv
// Front end: accepts angle words, reduces them modulo 360 and forms half angles.
// Depends on e2q_pkg.
module e2q_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [95:0]          s_data,
    input  e2q_pkg::fifo_stat_t  stat,
    output logic                 push,
    output e2q_pkg::front_item_t item
);
    import e2q_pkg::*;

    localparam int NS = MOD_STEPS + 2;

    logic              valid_reg [0:NS-1];
    logic [32:0]       rem_reg   [0:MOD_STEPS][3];
    logic [QW-1:0]     z_reg     [3];
    logic [2:0]        flip_reg;
    logic              adv;
    logic signed [QW-1:0] zfull [3];

    assign adv     = !valid_reg[NS-1] || !stat.full;
    assign s_ready = adv;
    assign push    = valid_reg[NS-1] && !stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k < NS; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            zfull[a] = signed'({1'b0, rem_reg[MOD_STEPS][a]}) <<< 7;
    end

    // lift into positive range, subtract 360 times 128..1, then fold half angles above 90 by 180
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[0][a] <= {s_data[32*a+31], s_data[32*a +: 32]} + MOD_OFFSET;
                for (int s = 0; s < MOD_STEPS; s++)
                begin
                    if (rem_reg[s][a] >= (DEG360_Q16 << (MOD_STEPS - 1 - s)))
                        rem_reg[s+1][a] <= rem_reg[s][a] - (DEG360_Q16 << (MOD_STEPS - 1 - s));
                    else
                        rem_reg[s+1][a] <= rem_reg[s][a];
                end
                if (zfull[a] > DEG90_Q24)
                begin
                    z_reg[a]    <= zfull[a] - DEG180_Q24;
                    flip_reg[a] <= 1'b1;
                end
                else
                begin
                    z_reg[a]    <= zfull[a];
                    flip_reg[a] <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            item.z[a] = z_reg[a];
        item.flip = flip_reg;
    end

endmodule

### design/e2q_fifo.sv
// Short queue between the front end and the CORDIC back end.
// Depends on e2q_pkg.
module e2q_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  e2q_pkg::front_item_t wr_item,
    input  logic                 pop,
    output e2q_pkg::front_item_t rd_item,
    output e2q_pkg::fifo_stat_t  stat
);
    import e2q_pkg::*;

    front_item_t        mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, rd_reg;
    logic [FIFO_AW:0]   cnt_reg;

    assign stat.full  = (cnt_reg == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_item    = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### design/e2q_back.sv
// Back end: CORDIC sine and cosine stages, triple products, rounding to Q1.15.
// Depends on e2q_pkg.
module e2q_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  e2q_pkg::fifo_stat_t  stat,
    input  e2q_pkg::front_item_t item,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_data
);
    import e2q_pkg::*;

    localparam int N  = CORDIC_ITERS;
    localparam int NV = N + 5;

    logic        v_reg    [0:NV-1];
    q30_t        x_reg    [0:N][3];
    q30_t        y_reg    [0:N][3];
    q30_t        z_reg    [0:N][3];
    logic [2:0]  flip_reg [0:N];
    q30_t        s_reg [3];
    q30_t        c_reg [3];
    logic signed [2*QW-1:0] p_reg [4];
    q30_t        sp_reg, cp_reg;
    logic signed [2*QW-1:0] t_reg [8];
    logic [15:0] q_reg [4];
    logic        be;

    function automatic q30_t rnd30(input logic signed [2*QW-1:0] p);
        logic signed [2*QW-1:0] t;
        t = (p + (68'sd1 <<< 29)) >>> 30;
        return t[QW-1:0];
    endfunction

    function automatic logic [15:0] to_q15(input logic signed [2*QW:0] v);
        logic signed [2*QW:0] t;
        t = (v + (69'sd1 <<< 44)) >>> 45;
        if (t > 69'sd32767)
            return 16'h7fff;
        else if (t < -69'sd32768)
            return 16'h8000;
        else
            return t[15:0];
    endfunction

    assign be      = !v_reg[NV-1] || m_ready;
    assign pop     = be && !stat.empty;
    assign m_valid = v_reg[NV-1];
    assign m_data  = {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NV; k++)
                v_reg[k] <= 1'b0;
        end
        else if (be)
        begin
            v_reg[0] <= !stat.empty;
            for (int k = 1; k < NV; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            flip_reg[0] <= item.flip;
            for (int a = 0; a < 3; a++)
            begin
                x_reg[0][a] <= GAIN_Q30;
                y_reg[0][a] <= '0;
                z_reg[0][a] <= item.z[a];
            end
            for (int i = 0; i < N; i++)
            begin
                flip_reg[i+1] <= flip_reg[i];
                for (int a = 0; a < 3; a++)
                begin
                    if (z_reg[i][a] >= 0)
                    begin
                        x_reg[i+1][a] <= x_reg[i][a] - (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] + (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] - atan_q24(i);
                    end
                    else
                    begin
                        x_reg[i+1][a] <= x_reg[i][a] + (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] - (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] + atan_q24(i);
                    end
                end
            end
            for (int a = 0; a < 3; a++)
            begin
                s_reg[a] <= flip_reg[N][a] ? -y_reg[N][a] : y_reg[N][a];
                c_reg[a] <= flip_reg[N][a] ? -x_reg[N][a] : x_reg[N][a];
            end
            // pair products: cy*cr, sy*sr, cy*sr, sy*cr
            p_reg[0] <= c_reg[0] * c_reg[2];
            p_reg[1] <= s_reg[0] * s_reg[2];
            p_reg[2] <= c_reg[0] * s_reg[2];
            p_reg[3] <= s_reg[0] * c_reg[2];
            sp_reg   <= s_reg[1];
            cp_reg   <= c_reg[1];
            t_reg[0] <= rnd30(p_reg[0]) * cp_reg;
            t_reg[1] <= rnd30(p_reg[1]) * sp_reg;
            t_reg[2] <= rnd30(p_reg[2]) * cp_reg;
            t_reg[3] <= rnd30(p_reg[3]) * sp_reg;
            t_reg[4] <= rnd30(p_reg[0]) * sp_reg;
            t_reg[5] <= rnd30(p_reg[1]) * cp_reg;
            t_reg[6] <= rnd30(p_reg[3]) * cp_reg;
            t_reg[7] <= rnd30(p_reg[2]) * sp_reg;
            q_reg[0] <= to_q15((2*QW+1)'(t_reg[0]) + (2*QW+1)'(t_reg[1]));
            q_reg[1] <= to_q15((2*QW+1)'(t_reg[2]) - (2*QW+1)'(t_reg[3]));
            q_reg[2] <= to_q15((2*QW+1)'(t_reg[4]) + (2*QW+1)'(t_reg[5]));
            q_reg[3] <= to_q15((2*QW+1)'(t_reg[6]) - (2*QW+1)'(t_reg[7]));
        end
    end

endmodule

### design/euler_to_quaternion_unit.sv
// Top level of the Euler (yaw, pitch, roll) to quaternion unit.
// Depends on e2q_pkg, e2q_front, e2q_fifo, e2q_back.
//
//  channel   dir  word layout (low bit first)
//  s_*       in   yaw_deg[31:0], pitch_deg[63:32], roll_deg[95:64]
//  m_*       out  quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
//
// One word per cycle sustained while m_tready stays high; an accepted word passes
// 10 front stages (8 of modulo reduction), the queue and CORDIC_STEPS + 5 back
// stages (one CORDIC stage per iteration) before m_tvalid is raised for it.
// Reset clears all valid bits and queue pointers; payload is not reset.
// A stall on m_* holds the back end, fills the queue, then holds the front end and drops s_tready.
module euler_to_quaternion_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // yaw_deg, pitch_deg, roll_deg
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // quat_w, quat_x, quat_y, quat_z
);
    import e2q_pkg::*;

    fifo_stat_t  stat;
    front_item_t wr_item, rd_item;
    logic        push, pop;

    e2q_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_data  (s_tdata),
        .stat    (stat),
        .push    (push),
        .item    (wr_item)
    );

    e2q_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .stat    (stat)
    );

    e2q_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .stat    (stat),
        .item    (rd_item),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

endmodule

### design/e2q_checker.sv
// Port-level checks of euler_to_quaternion_unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module e2q_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    logic [7:0] inflight_reg;
    logic       acc_in, acc_out;

    assign acc_in  = s_tvalid && s_tready;
    assign acc_out = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else if (acc_in && !acc_out)
            inflight_reg <= inflight_reg + 1'b1;
        else if (acc_out && !acc_in)
            inflight_reg <= inflight_reg - 1'b1;
    end

    `CHK_RUN(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result word dropped")
    `CHK_RUN(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled word changed")
    `CHK_RUN(a_no_invent, acc_out |-> inflight_reg != 8'd0, "word without input")
    `CHK_ALL(a_reset_idle, !rst_n |=> !m_tvalid, "valid out of reset")

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (.*);

### bench/tb.sv
// Testbench for euler_to_quaternion_unit: yaw, pitch and roll words go in, quaternion words out.
// Each result is predicted by a bit-exact CORDIC model in this file and checked in order.
// Depends on e2q_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
    import e2q_pkg::*;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } quat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    quat_t quat_q[$];
    int    mismatches;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_cycles;
    int    quiet_cycles;
    bit    timed_out;

    localparam int WATCHDOG_LIMIT = 20000;

    euler_to_quaternion_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl[30] = '{754974720, 445687602, 235489088, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115, 57, 29, 14, 7, 4, 2};
        return tbl[i];
    endfunction

    task automatic half_angle_sincos(input logic [31:0] ang, output longint s,
                                     output longint c);
        longint a, z, x, y, xs, ys;
        bit     flip;
        a = longint'($signed(ang)) % 64'sd23592960;
        if (a < 0)
            a += 23592960;
        z = a * 128;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (z > 64'sd1509949440)
        begin
            z -= 64'sd3019898880;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 30; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_entry(i);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_entry(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint triple_q60(longint a, longint b, longint c);
        longint ab;
        ab = shr_floor(a * b + (64'sd1 <<< 29), 30);
        return ab * c;
    endfunction

    function automatic logic [15:0] round_sat_q15(longint q60);
        longint v;
        v = shr_floor(q60 + (64'sd1 <<< 44), 45);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic predict_quat(input logic [95:0] d, output quat_t q);
        longint sy, cy, sp, cp, sr, cr;
        half_angle_sincos(d[31:0], sy, cy);
        half_angle_sincos(d[63:32], sp, cp);
        half_angle_sincos(d[95:64], sr, cr);
        q.w = round_sat_q15(triple_q60(cy, cr, cp) + triple_q60(sy, sr, sp));
        q.x = round_sat_q15(triple_q60(cy, sr, cp) - triple_q60(sy, cr, sp));
        q.y = round_sat_q15(triple_q60(cy, cr, sp) + triple_q60(sy, sr, cp));
        q.z = round_sat_q15(triple_q60(sy, cr, cp) - triple_q60(cy, sr, sp));
    endtask

    task automatic send_angles(input logic [31:0] yaw, input logic [31:0] pitch,
                               input logic [31:0] roll);
        quat_t q;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {roll, pitch, yaw};
        @(posedge clk iff s_tready);
        predict_quat({roll, pitch, yaw}, q);
        quat_q.push_back(q);
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 360) << 16;
            2: return 32'($signed(-($urandom_range(0, 720)))) <<< 16;
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic drain_quats();
        s_tvalid <= 1'b0;
        while (quat_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [31:0] vals[12] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
            32'd1, 90 << 16, 180 << 16, 270 << 16, 360 << 16, 32'(-90 <<< 16),
            (180 << 16) + 1, (180 << 16) - 1};
        for (int i = 0; i < 12; i++)
            send_angles(vals[i], vals[(i + 5) % 12], vals[(i + 9) % 12]);
        for (int i = 0; i < 8; i++)
            send_angles(vals[i + 4], vals[i + 4], vals[i + 4]);
        send_angles(32'h55555555, 32'haaaaaaaa, 32'h55555555);
        send_angles(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        for (int i = 0; i < 60; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
        drain_quats();
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        quat_t got;
        quat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (quat_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", got);
            end
            else
            begin
                want = quat_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d (exp/got)",
                            want.w, got.w, want.x, got.x, want.y, got.y, want.z, got.z);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 75;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(250);
        test_backpressure();
        send_idle_pct = 75;
        recv_idle_pct = 26;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        drain_quats();
        repeat (CORDIC_STEPS + 40) @(posedge clk);
        if (mismatches == 0 && quat_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### euler_to_quaternion_unit.f
+incdir+design
design/e2q_pkg.sv
design/e2q_front.sv
design/e2q_fifo.sv
design/e2q_back.sv
design/euler_to_quaternion_unit.sv
design/e2q_checker.sv
bench/tb.sv
